// ===== rtl/core/lcdnw_pkg.sv =====
// Shared types, constants and tables for the character LCD nibble write sequencer
`timescale 1ns / 1ps

package lcdnw_pkg;

   localparam int WAIT_WIDTH  = 14;
   localparam int LOAD_WIDTH  = 14;
   localparam int SAT_WIDTH   = (WAIT_WIDTH > LOAD_WIDTH) ? WAIT_WIDTH : LOAD_WIDTH;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_CMD    = 3'd1;
   localparam logic [2:0] MODE_DATA   = 3'd2;
   localparam logic [2:0] MODE_INIT   = 3'd3;
   localparam logic [2:0] MODE_CURSOR = 3'd4;

   localparam logic [1:0] CSR_STROBE = 2'd0;
   localparam logic [1:0] CSR_LEAD   = 2'd1;
   localparam logic [1:0] CSR_POWER  = 2'd2;

   localparam logic [7:0] ROW1_BASE = 8'hC0;
   localparam logic [7:0] ROW0_BASE = 8'h80;
   localparam logic [3:0] INIT_LAST = 4'd9;

   localparam logic [7:0]  STROBE_RESET = 8'd5;
   localparam logic [9:0]  LEAD_RESET   = 10'd100;
   localparam logic [13:0] POWER_RESET  = 14'd15000;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_CMD  = 2'd1,
      OP_DATA = 2'd2,
      OP_INIT = 2'd3
   } lcdnw_op_type;

   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_LEAD    = 8'b0000_0010,
      PH_HI_RISE = 8'b0000_0100,
      PH_HI_FALL = 8'b0000_1000,
      PH_LO_RISE = 8'b0001_0000,
      PH_LO_FALL = 8'b0010_0000,
      PH_GAP     = 8'b0100_0000,
      PH_POWER   = 8'b1000_0000
   } lcdnw_phase_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] byte_value;
      logic       row;
      logic [5:0] column;
   } lcdnw_req_type;

   typedef struct packed {
      logic [3:0] bus_nibble;
      logic       register_select;
      logic       enable_line;
      logic       bus_driven;
      logic       busy_res;
      logic       rejected;
   } lcdnw_rsp_type;

   typedef struct packed {
      lcdnw_op_type op;
      logic [7:0]   byte_value;
   } lcdnw_job_type;

   typedef struct packed {
      logic [3:0] nib;
      logic       rs;
      logic       en;
      logic       drv;
   } lcdnw_pins_type;

   function automatic logic [7:0] lcdnw_visible(input logic busy, input lcdnw_pins_type p);
      lcdnw_visible = {busy, p.drv, p.en, p.rs, (p.drv ? p.nib : 4'd0)};
   endfunction

   function automatic logic [WAIT_WIDTH-1:0] lcdnw_sat_wait(input logic [LOAD_WIDTH-1:0] v);
      logic [SAT_WIDTH-1:0] ext;
      logic [SAT_WIDTH-1:0] lim;
      ext = SAT_WIDTH'(v);
      lim = SAT_WIDTH'({WAIT_WIDTH{1'b1}});
      if (ext > lim) begin
         lcdnw_sat_wait = {WAIT_WIDTH{1'b1}};
      end else begin
         lcdnw_sat_wait = WAIT_WIDTH'(ext);
      end
   endfunction

   function automatic logic [7:0] lcdnw_init_cmd(input logic [3:0] pos);
      unique case (pos)
         4'd0:    lcdnw_init_cmd = 8'h30;
         4'd1:    lcdnw_init_cmd = 8'h30;
         4'd2:    lcdnw_init_cmd = 8'h32;
         4'd3:    lcdnw_init_cmd = 8'h28;
         4'd4:    lcdnw_init_cmd = 8'h08;
         4'd5:    lcdnw_init_cmd = 8'h0F;
         4'd6:    lcdnw_init_cmd = 8'h01;
         4'd7:    lcdnw_init_cmd = 8'h04;
         4'd8:    lcdnw_init_cmd = 8'h06;
         4'd9:    lcdnw_init_cmd = 8'h0C;
         default: lcdnw_init_cmd = 8'h00;
      endcase
   endfunction

   function automatic logic [LOAD_WIDTH-1:0] lcdnw_init_gap(input logic [3:0] pos);
      unique case (pos)
         4'd0:    lcdnw_init_gap = LOAD_WIDTH'(5000);
         4'd1:    lcdnw_init_gap = LOAD_WIDTH'(100);
         4'd2:    lcdnw_init_gap = LOAD_WIDTH'(200);
         4'd3:    lcdnw_init_gap = LOAD_WIDTH'(100);
         4'd4:    lcdnw_init_gap = LOAD_WIDTH'(100);
         4'd5:    lcdnw_init_gap = LOAD_WIDTH'(100);
         4'd6:    lcdnw_init_gap = LOAD_WIDTH'(100);
         4'd7:    lcdnw_init_gap = LOAD_WIDTH'(200);
         default: lcdnw_init_gap = '0;
      endcase
   endfunction

endpackage

// ===== rtl/core/lcdnw_front.sv =====
// Front end: accepts items, drops unknown modes, classifies into jobs
`timescale 1ns / 1ps

module lcdnw_front (
   input  logic                    req_valid,
   input  lcdnw_pkg::lcdnw_req_type req_data,
   output logic                    req_stall,
   input  logic                    q_full,
   output logic                    push_valid,
   output lcdnw_pkg::lcdnw_job_type push_data
);

   logic known;

   always_comb begin
      known = 1'b1;
      push_data.op = lcdnw_pkg::OP_TICK;
      push_data.byte_value = req_data.byte_value;
      unique case (req_data.mode)
         lcdnw_pkg::MODE_TICK: begin
            push_data.op = lcdnw_pkg::OP_TICK;
         end
         lcdnw_pkg::MODE_CMD: begin
            push_data.op = lcdnw_pkg::OP_CMD;
         end
         lcdnw_pkg::MODE_DATA: begin
            push_data.op = lcdnw_pkg::OP_DATA;
         end
         lcdnw_pkg::MODE_INIT: begin
            push_data.op = lcdnw_pkg::OP_INIT;
         end
         lcdnw_pkg::MODE_CURSOR: begin
            push_data.op = lcdnw_pkg::OP_CMD;
            push_data.byte_value = (req_data.row ? lcdnw_pkg::ROW1_BASE : lcdnw_pkg::ROW0_BASE)
                                   + {2'b00, req_data.column};
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_stall  = q_full;
   assign push_valid = req_valid && known;

endmodule

// ===== rtl/core/lcdnw_queue.sv =====
// Job queue between front end and sequencer
`timescale 1ns / 1ps

module lcdnw_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  lcdnw_pkg::lcdnw_job_type push_data,
   output logic                     full,
   input  logic                     pop,
   output lcdnw_pkg::lcdnw_job_type pop_data,
   output logic                     empty
);

   lcdnw_pkg::lcdnw_job_type             mem_ff [lcdnw_pkg::QUEUE_DEPTH];
   logic [lcdnw_pkg::QPTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [lcdnw_pkg::QPTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [lcdnw_pkg::QPTR_WIDTH:0]       count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full     = (count_ff == (lcdnw_pkg::QPTR_WIDTH+1)'(lcdnw_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/lcdnw_back.sv =====
// Sequencer: runs jobs, steps the pin timing, registers results
`timescale 1ns / 1ps

module lcdnw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [13:0]              csr_wdata,
   input  logic                     q_empty,
   input  lcdnw_pkg::lcdnw_job_type q_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   output lcdnw_pkg::lcdnw_rsp_type rsp_data,
   input  logic                     rsp_stall
);

   logic [7:0]                          strobe_ff;
   logic [9:0]                          lead_ff;
   logic [13:0]                         power_ff;

   logic                                busy_ff, busy_in;
   lcdnw_pkg::lcdnw_phase_type          phase_ff, phase_in;
   logic [lcdnw_pkg::WAIT_WIDTH-1:0]    wait_ff, wait_in;
   logic [7:0]                          held_byte_ff, held_byte_in;
   logic                                held_sel_ff, held_sel_in;
   logic [3:0]                          init_pos_ff, init_pos_in;
   logic                                in_init_ff, in_init_in;
   lcdnw_pkg::lcdnw_pins_type           pins_ff, pins_in;
   logic [7:0]                          before_ff, before_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   lcdnw_pkg::lcdnw_rsp_type            rsp_data_ff, rsp_data_in;

   logic                                chain, out_free, work;
   logic                                do_drive, drv_sel, do_finish, rej, emit;
   logic [7:0]                          drv_byte, prior, after;

   assign chain    = busy_ff && (wait_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign work     = out_free && (chain || !q_empty);
   assign q_pop    = out_free && !chain && !q_empty;

   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      held_byte_in = held_byte_ff;
      held_sel_in  = held_sel_ff;
      init_pos_in  = init_pos_ff;
      in_init_in   = in_init_ff;
      pins_in      = pins_ff;
      do_drive     = 1'b0;
      do_finish    = 1'b0;
      drv_byte     = held_byte_ff;
      drv_sel      = held_sel_ff;
      rej          = 1'b0;
      prior        = chain ? before_ff : lcdnw_pkg::lcdnw_visible(busy_ff, pins_ff);

      if (work) begin
         if (chain) begin
            unique case (phase_ff)
               lcdnw_pkg::PH_LEAD: begin
                  do_drive = 1'b1;
               end
               lcdnw_pkg::PH_HI_RISE: begin
                  pins_in.en = 1'b1;
                  wait_in    = lcdnw_pkg::lcdnw_sat_wait(
                                  lcdnw_pkg::LOAD_WIDTH'(strobe_ff));
                  phase_in   = lcdnw_pkg::PH_HI_FALL;
               end
               lcdnw_pkg::PH_LO_RISE: begin
                  pins_in.en = 1'b1;
                  wait_in    = lcdnw_pkg::lcdnw_sat_wait(
                                  lcdnw_pkg::LOAD_WIDTH'(strobe_ff));
                  phase_in   = lcdnw_pkg::PH_LO_FALL;
               end
               lcdnw_pkg::PH_HI_FALL: begin
                  pins_in.en  = 1'b0;
                  pins_in.nib = held_byte_ff[3:0];
                  wait_in     = lcdnw_pkg::lcdnw_sat_wait(
                                   lcdnw_pkg::LOAD_WIDTH'(strobe_ff));
                  phase_in    = lcdnw_pkg::PH_LO_RISE;
               end
               lcdnw_pkg::PH_LO_FALL: begin
                  pins_in.en  = 1'b0;
                  pins_in.drv = 1'b0;
                  if (in_init_ff && (init_pos_ff < lcdnw_pkg::INIT_LAST)) begin
                     wait_in     = lcdnw_pkg::lcdnw_sat_wait(
                                      lcdnw_pkg::lcdnw_init_gap(init_pos_ff));
                     init_pos_in = init_pos_ff + 4'd1;
                     phase_in    = lcdnw_pkg::PH_GAP;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
               lcdnw_pkg::PH_GAP: begin
                  do_drive = 1'b1;
                  drv_byte = lcdnw_pkg::lcdnw_init_cmd(init_pos_ff);
                  drv_sel  = 1'b0;
               end
               lcdnw_pkg::PH_POWER: begin
                  init_pos_in = 4'd0;
                  do_drive    = 1'b1;
                  drv_byte    = lcdnw_pkg::lcdnw_init_cmd(4'd0);
                  drv_sel     = 1'b0;
               end
               default: begin
                  do_finish = 1'b1;
               end
            endcase
         end else if (q_data.op == lcdnw_pkg::OP_TICK) begin
            if (busy_ff && (wait_ff != '0)) begin
               wait_in = wait_ff - 1'b1;
            end
         end else if (busy_ff) begin
            rej = 1'b1;
         end else begin
            busy_in    = 1'b1;
            in_init_in = 1'b0;
            unique case (q_data.op)
               lcdnw_pkg::OP_DATA: begin
                  held_byte_in = q_data.byte_value;
                  held_sel_in  = 1'b1;
                  wait_in      = lcdnw_pkg::lcdnw_sat_wait(
                                    lcdnw_pkg::LOAD_WIDTH'(lead_ff));
                  phase_in     = lcdnw_pkg::PH_LEAD;
               end
               lcdnw_pkg::OP_INIT: begin
                  in_init_in  = 1'b1;
                  init_pos_in = 4'd0;
                  pins_in     = '{nib: 4'd0, rs: 1'b0, en: 1'b0, drv: 1'b1};
                  wait_in     = lcdnw_pkg::lcdnw_sat_wait(
                                   lcdnw_pkg::LOAD_WIDTH'(power_ff));
                  phase_in    = lcdnw_pkg::PH_POWER;
               end
               default: begin
                  do_drive = 1'b1;
                  drv_byte = q_data.byte_value;
                  drv_sel  = 1'b0;
               end
            endcase
         end
      end

      if (do_drive) begin
         held_byte_in = drv_byte;
         held_sel_in  = drv_sel;
         pins_in      = '{nib: drv_byte[7:4], rs: drv_sel, en: 1'b0, drv: 1'b1};
         wait_in      = lcdnw_pkg::lcdnw_sat_wait(lcdnw_pkg::LOAD_WIDTH'(strobe_ff));
         phase_in     = lcdnw_pkg::PH_HI_RISE;
      end
      if (do_finish) begin
         busy_in    = 1'b0;
         in_init_in = 1'b0;
         phase_in   = lcdnw_pkg::PH_IDLE;
         wait_in    = '0;
      end

      after     = lcdnw_pkg::lcdnw_visible(busy_in, pins_in);
      before_in = q_pop ? prior : before_ff;
      emit      = work && !(busy_in && (wait_in == '0)) && (rej || (after != prior));

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{bus_nibble: after[3:0], register_select: after[4],
                          enable_line: after[5], bus_driven: after[6],
                          busy_res: after[7], rejected: rej};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= lcdnw_pkg::STROBE_RESET;
         lead_ff   <= lcdnw_pkg::LEAD_RESET;
         power_ff  <= lcdnw_pkg::POWER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lcdnw_pkg::CSR_STROBE: strobe_ff <= csr_wdata[7:0];
            lcdnw_pkg::CSR_LEAD:   lead_ff   <= csr_wdata[9:0];
            lcdnw_pkg::CSR_POWER:  power_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= lcdnw_pkg::PH_IDLE;
         wait_ff      <= '0;
         held_byte_ff <= 8'd0;
         held_sel_ff  <= 1'b0;
         init_pos_ff  <= 4'd0;
         in_init_ff   <= 1'b0;
         pins_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         held_byte_ff <= held_byte_in;
         held_sel_ff  <= held_sel_in;
         init_pos_ff  <= init_pos_in;
         in_init_ff   <= in_init_in;
         pins_ff      <= pins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      before_ff   <= before_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/char_lcd_nibble_write_sequencer.sv =====
// Top level of the character LCD 4-bit nibble write sequencer
//
//   port group | direction | handshake           | payload
//   req_       | in        | req_valid/req_stall | lcdnw_req_type (mode, byte, row, column)
//   rsp_       | out       | rsp_valid/rsp_stall | lcdnw_rsp_type (pin levels, busy, rejected)
//   csr_       | in        | csr_we              | csr_index, csr_wdata
//
// An item enters the four-entry job queue every cycle while the queue has room.
// The sequencer takes one queued item per cycle while its output is free; a timing
// step whose wait has run out goes first. The result lands in a registered output.
// Reset empties the queue, drives all lines low with the bus released and loads
// default timings. A stalled result holds the sequencer; the queue keeps filling.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  lcdnw_pkg::lcdnw_req_type req_data,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output lcdnw_pkg::lcdnw_rsp_type rsp_data,
   input  logic                     rsp_stall,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [13:0]              csr_wdata
);

   logic                     q_full, q_empty, q_pop, push_valid;
   lcdnw_pkg::lcdnw_job_type push_data, pop_data;

   lcdnw_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   lcdnw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .pop_data   (pop_data),
      .empty      (q_empty)
   );

   lcdnw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
